// ===== hw/rtl/hee_pkg.sv =====
package hee_pkg;

    // kind of run an input byte expands into
    typedef logic [2:0] t_kind;
    typedef logic [2:0] t_idx;

    localparam t_kind KIND_PLAIN = 3'd0;
    localparam t_kind KIND_LT    = 3'd1;
    localparam t_kind KIND_GT    = 3'd2;
    localparam t_kind KIND_QUOT  = 3'd3;
    localparam t_kind KIND_AMP   = 3'd4;
    localparam t_kind KIND_BR    = 3'd5;

    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_QUOT = 8'h22;
    localparam logic [7:0] CH_AMP  = 8'h26;
    localparam logic [7:0] CH_LT   = 8'h3C;
    localparam logic [7:0] CH_GT   = 8'h3E;

    // index of the final byte of a run
    function automatic t_idx run_last(input t_kind kind);
        t_idx v;
        case (kind)
            KIND_PLAIN: v = 3'd0;
            KIND_LT:    v = 3'd3;
            KIND_GT:    v = 3'd3;
            KIND_QUOT:  v = 3'd5;
            KIND_AMP:   v = 3'd4;
            KIND_BR:    v = 3'd4;
            default:    v = 3'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/hee_in_if.sv =====
interface hee_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       first_of_string;

    modport source (output valid, output in_byte, output first_of_string, input ready);
    modport sink   (input valid, input in_byte, input first_of_string, output ready);
endinterface

// ===== hw/rtl/hee_out_if.sv =====
interface hee_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       last_of_run;

    modport source (output valid, output out_byte, output last_of_run, input ready);
    modport sink   (input valid, input out_byte, input last_of_run, output ready);
endinterface

// ===== hw/rtl/hee_entity_rom.sv =====
module hee_entity_rom (
    input  hee_pkg::t_kind i_kind,
    input  hee_pkg::t_idx  i_idx,
    input  logic [7:0]     i_char,
    output logic [7:0]     o_byte
);

    always_comb begin
        o_byte = i_char;
        case (i_kind)
            hee_pkg::KIND_LT: begin
                case (i_idx)
                    3'd0:    o_byte = "&";
                    3'd1:    o_byte = "l";
                    3'd2:    o_byte = "t";
                    default: o_byte = ";";
                endcase
            end
            hee_pkg::KIND_GT: begin
                case (i_idx)
                    3'd0:    o_byte = "&";
                    3'd1:    o_byte = "g";
                    3'd2:    o_byte = "t";
                    default: o_byte = ";";
                endcase
            end
            hee_pkg::KIND_QUOT: begin
                case (i_idx)
                    3'd0:    o_byte = "&";
                    3'd1:    o_byte = "q";
                    3'd2:    o_byte = "u";
                    3'd3:    o_byte = "o";
                    3'd4:    o_byte = "t";
                    default: o_byte = ";";
                endcase
            end
            hee_pkg::KIND_AMP: begin
                case (i_idx)
                    3'd0:    o_byte = "&";
                    3'd1:    o_byte = "a";
                    3'd2:    o_byte = "m";
                    3'd3:    o_byte = "p";
                    default: o_byte = ";";
                endcase
            end
            hee_pkg::KIND_BR: begin
                case (i_idx)
                    3'd0:    o_byte = "<";
                    3'd1:    o_byte = "B";
                    3'd2:    o_byte = "R";
                    3'd3:    o_byte = ">";
                    default: o_byte = hee_pkg::CH_CR;
                endcase
            end
            default: o_byte = i_char;
        endcase
    end

endmodule

// ===== hw/rtl/html_entity_escaper.sv =====
// html entity escaper
//
// input channel i_in carries one text byte per beat plus a first_of_string
// flag that clears the carriage-return memory. output channel o_out carries
// one escaped byte per beat; last_of_run marks the final beat caused by an
// input byte.
// an input byte passes through the hold register and then the output
// register before its first output beat is valid.
// throughput: a byte that passes through yields one beat, so plain text
// streams at one beat per cycle while the receiver does not stall. an entity
// is 4 to 6 bytes; the hold register is stepped by the run index counter,
// and the next input beat is taken in the cycle the last byte leaves.
// a line feed right after a carriage return produces no output beat.
// reset (i_rst_n low, synchronous) empties the hold and output registers
// and clears the carriage-return memory.
// when the receiver stalls, the output register holds its beat and the
// hold register keeps the current byte; input is taken again as soon as
// the final output beat of the held byte can move.
module html_entity_escaper (
    input logic          i_clk,
    input logic          i_rst_n,
    hee_in_if.sink       i_in,
    hee_out_if.source    o_out
);

    // hold register: byte being expanded
    logic           r_pend, n_pend;
    hee_pkg::t_kind r_kind, n_kind;
    logic [7:0]     r_char, n_char;
    hee_pkg::t_idx  r_idx,  n_idx;
    logic           r_prev_cr, n_prev_cr;

    // output register
    logic           r_out_valid, n_out_valid;
    logic [7:0]     r_out_byte,  n_out_byte;
    logic           r_out_last,  n_out_last;

    logic           w_adv;
    logic           w_last;
    logic           w_accept;
    logic           w_after_cr;
    logic           w_suppress;
    hee_pkg::t_kind w_new_kind;
    logic [7:0]     w_rom_byte;

    hee_entity_rom u_rom (
        .i_kind (r_kind),
        .i_idx  (r_idx),
        .i_char (r_char),
        .o_byte (w_rom_byte)
    );

    // output register can take a new beat
    assign w_adv  = !r_out_valid || o_out.ready;
    // held byte emits its final beat this cycle
    assign w_last = r_pend && w_adv && (r_idx == hee_pkg::run_last(r_kind));

    assign i_in.ready = !r_pend || w_last;
    assign w_accept   = i_in.valid && i_in.ready;

    assign w_after_cr = !i_in.first_of_string && r_prev_cr;

    // classify the incoming byte
    always_comb begin
        w_suppress = 1'b0;
        case (i_in.in_byte)
            hee_pkg::CH_LT:   w_new_kind = hee_pkg::KIND_LT;
            hee_pkg::CH_GT:   w_new_kind = hee_pkg::KIND_GT;
            hee_pkg::CH_QUOT: w_new_kind = hee_pkg::KIND_QUOT;
            hee_pkg::CH_AMP:  w_new_kind = hee_pkg::KIND_AMP;
            hee_pkg::CH_CR:   w_new_kind = hee_pkg::KIND_BR;
            hee_pkg::CH_LF: begin
                w_new_kind = hee_pkg::KIND_BR;
                w_suppress = w_after_cr;
            end
            default:          w_new_kind = hee_pkg::KIND_PLAIN;
        endcase
    end

    always_comb begin
        n_pend      = r_pend;
        n_kind      = r_kind;
        n_char      = r_char;
        n_idx       = r_idx;
        n_prev_cr   = r_prev_cr;
        n_out_valid = r_out_valid;
        n_out_byte  = r_out_byte;
        n_out_last  = r_out_last;

        if (o_out.ready) begin
            n_out_valid = 1'b0;
        end

        // step the held byte into the output register
        if (r_pend && w_adv) begin
            n_out_valid = 1'b1;
            n_out_byte  = w_rom_byte;
            n_out_last  = w_last;
            n_idx       = r_idx + 3'd1;
            if (w_last) begin
                n_pend = 1'b0;
            end
        end

        // take a new byte; a suppressed line feed leaves nothing to hold
        if (w_accept) begin
            n_prev_cr = (i_in.in_byte == hee_pkg::CH_CR);
            n_pend    = !w_suppress;
            n_kind    = w_new_kind;
            n_char    = i_in.in_byte;
            n_idx     = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend      <= 1'b0;
            r_prev_cr   <= 1'b0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
        end else begin
            r_pend      <= n_pend;
            r_prev_cr   <= n_prev_cr;
            r_out_valid <= n_out_valid;
            r_idx       <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind     <= n_kind;
        r_char     <= n_char;
        r_out_byte <= n_out_byte;
        r_out_last <= n_out_last;
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.out_byte    = r_out_byte;
    assign o_out.last_of_run = r_out_last;

endmodule
